// ===== sv/arp_reply_spoof_detector_unit_macros.svh =====
// Assertion macros for the ARP reply spoof detector.
// Used by the checker module only; expects clk and rst_n in scope.
`ifndef ARP_REPLY_SPOOF_DETECTOR_UNIT_MACROS_SVH
`define ARP_REPLY_SPOOF_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, silenced during reset.
`define ARPSD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpsd: same-cycle check failed");

// Next-cycle implication, silenced during reset.
`define ARPSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpsd: next-cycle check failed");

`endif

// ===== sv/arpsd_pkg.sv =====
// Shared types and constants for the ARP reply spoof detector.
// No dependencies.
package arpsd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int ENTRY_W = IP_W + MAC_W;

  localparam logic [POS_W-1:0]  POS_OPCODE   = POS_W'(21);
  localparam logic [POS_W-1:0]  POS_MAC      = POS_W'(22);
  localparam logic [POS_W-1:0]  POS_IP       = POS_W'(28);
  localparam logic [POS_W-1:0]  POS_FULL     = POS_W'(32);
  localparam logic [BYTE_W-1:0] OPCODE_REPLY = BYTE_W'(2);

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_HIT   = 2'd1,
    OUT_LEARN = 2'd2,
    OUT_FULL  = 2'd3
  } out_kind_t;

  typedef struct packed {
    logic      cap_en;
    logic      frame_clr;
    logic      scan_start;
    logic      scan_rd;
    logic      learn;
    logic      out_load;
    out_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic reply_now;
    logic hit;
    logic more;
    logic full;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== sv/arpsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/arpsd_dp.sv =====
// Datapath: frame field capture, learned table, lookup compare and result register.
// Depends on arpsd_pkg and arpsd_ram.
module arpsd_dp import arpsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_frame_byte,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_is_reply,
  output logic              out_spoof_detected,
  output logic              out_entry_learned,
  output logic              out_table_full,
  output logic [IP_W-1:0]   out_sender_ip,
  output logic [MAC_W-1:0]  out_stored_mac,
  output logic [MAC_W-1:0]  out_new_mac
);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_cap;
  logic [BYTE_W-1:0] opc_r, opc_nxt, opc_cap;
  logic [MAC_W-1:0]  mac_r, mac_nxt, mac_cap;
  logic [IP_W-1:0]   ip_r, ip_nxt, ip_cap;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              is_reply_r, spoof_r, learned_r, full_r;
  logic [IP_W-1:0]   sip_r;
  logic [MAC_W-1:0]  smac_r, nmac_r;
  logic [ENTRY_W-1:0] rd_data;
  logic [IP_W-1:0]   rd_ip;
  logic [MAC_W-1:0]  rd_mac;

  // Field capture for the byte on the input
  always_comb begin
    opc_cap = opc_r;
    mac_cap = mac_r;
    ip_cap  = ip_r;
    priority if (pos_r == POS_OPCODE) begin
      opc_cap = in_frame_byte;
    end else if (pos_r >= POS_MAC && pos_r < POS_IP) begin
      mac_cap = {mac_r[MAC_W-BYTE_W-1:0], in_frame_byte};
    end else if (pos_r >= POS_IP && pos_r < POS_FULL) begin
      ip_cap = {ip_r[IP_W-BYTE_W-1:0], in_frame_byte};
    end
    pos_cap = (pos_r < POS_FULL) ? pos_r + POS_W'(1) : POS_FULL;
  end

  always_comb begin
    pos_nxt = pos_r;
    opc_nxt = opc_r;
    mac_nxt = mac_r;
    ip_nxt  = ip_r;
    priority if (cmd.frame_clr) begin
      pos_nxt = '0;
      opc_nxt = '0;
      mac_nxt = '0;
      ip_nxt  = '0;
    end else if (cmd.cap_en) begin
      pos_nxt = pos_cap;
      opc_nxt = opc_cap;
      mac_nxt = mac_cap;
      ip_nxt  = ip_cap;
    end
  end

  // Table scan
  assign idx_nxt  = cmd.scan_start ? '0 : (cmd.scan_rd ? idx_r + CNT_W'(1) : idx_r);
  assign pend_nxt = cmd.scan_rd;
  assign cnt_nxt  = cmd.learn ? cnt_r + CNT_W'(1) : cnt_r;

  arpsd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.learn),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data ({ip_r, mac_r}),
    .rd_en   (cmd.scan_rd),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_ip  = rd_data[ENTRY_W-1:MAC_W];
  assign rd_mac = rd_data[MAC_W-1:0];

  assign sts.reply_now = (pos_cap == POS_FULL) && (opc_cap == OPCODE_REPLY);
  assign sts.hit       = pend_r && (rd_ip == ip_r);
  assign sts.more      = idx_r < cnt_r;
  assign sts.full      = cnt_r == CNT_W'(TABLE_DEPTH);
  assign sts.out_busy  = out_valid_r;

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      opc_r       <= '0;
      mac_r       <= '0;
      ip_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      opc_r       <= opc_nxt;
      mac_r       <= mac_nxt;
      ip_r        <= ip_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      is_reply_r <= 1'b0;
      spoof_r    <= 1'b0;
      learned_r  <= 1'b0;
      full_r     <= 1'b0;
      sip_r      <= '0;
      smac_r     <= '0;
      nmac_r     <= '0;
      unique case (cmd.out_kind)
        OUT_NONE: begin
        end
        OUT_HIT: begin
          is_reply_r <= 1'b1;
          spoof_r    <= rd_mac != mac_r;
          sip_r      <= ip_r;
          smac_r     <= rd_mac;
          nmac_r     <= mac_r;
        end
        OUT_LEARN: begin
          is_reply_r <= 1'b1;
          learned_r  <= 1'b1;
          sip_r      <= ip_r;
          nmac_r     <= mac_r;
        end
        OUT_FULL: begin
          is_reply_r <= 1'b1;
          full_r     <= 1'b1;
          sip_r      <= ip_r;
          nmac_r     <= mac_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_reply       = is_reply_r;
  assign out_spoof_detected = spoof_r;
  assign out_entry_learned  = learned_r;
  assign out_table_full     = full_r;
  assign out_sender_ip      = sip_r;
  assign out_stored_mac     = smac_r;
  assign out_new_mac        = nmac_r;

endmodule

// ===== sv/arpsd_ctrl.sv =====
// Controller: byte reception and table scan sequencing.
// Depends on arpsd_pkg.
module arpsd_ctrl import arpsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last_byte,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_RX   = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_RX: begin
        // hold the final byte while the previous result is still waiting
        in_stall = sts.out_busy && in_last_byte;
        if (in_valid && !in_stall) begin
          cmd.cap_en = 1'b1;
          if (in_last_byte) begin
            if (sts.reply_now) begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end else begin
              cmd.out_load  = 1'b1;
              cmd.out_kind  = OUT_NONE;
              cmd.frame_clr = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        priority if (sts.hit) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = OUT_HIT;
          cmd.frame_clr = 1'b1;
          state_nxt     = ST_RX;
        end else if (sts.more) begin
          cmd.scan_rd = 1'b1;
        end else begin
          cmd.out_load  = 1'b1;
          cmd.frame_clr = 1'b1;
          if (sts.full) begin
            cmd.out_kind = OUT_FULL;
          end else begin
            cmd.learn    = 1'b1;
            cmd.out_kind = OUT_LEARN;
          end
          state_nxt = ST_RX;
        end
      end
      default: begin
        state_nxt = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/arp_reply_spoof_detector_unit.sv =====
// ARP reply spoof detector, top level: one frame byte per transfer, one result per frame.
// Throughput: one byte per cycle unless in_stall is high; the final byte of a reply frame
//   blocks input until the scan ends on a match, or after every stored entry if the IP is new.
// Latency: the result is valid the cycle after the final byte (short or non-reply frame)
//   or the cycle after the table scan ends; the scan reads one table entry per cycle.
// Reset: synchronous, active low; clears the frame capture, entry count and result valid.
module arp_reply_spoof_detector_unit import arpsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_frame_byte,
  input  logic              in_last_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_reply,
  output logic              out_spoof_detected,
  output logic              out_entry_learned,
  output logic              out_table_full,
  output logic [IP_W-1:0]   out_sender_ip,
  output logic [MAC_W-1:0]  out_stored_mac,
  output logic [MAC_W-1:0]  out_new_mac
);

  // Command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: takes bytes while receiving, walks the table after a reply frame ends.
  // Hold every transfer while the table is walked; outside the walk, the only transfer
  // it holds off is a final byte arriving while a result still waits, so ordinary
  // frame bytes keep flowing into the capture registers.
  arpsd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Datapath: captures opcode, sender MAC and sender IP by byte position, holds the
  // learned IP-to-MAC table in a RAM filled from entry zero upward, compares each
  // returned entry against the captured IP, and keeps the result in an output register
  // so that the next frame's bytes can be taken while the result waits downstream.
  arpsd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_frame_byte      (in_frame_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_is_reply       (out_is_reply),
    .out_spoof_detected (out_spoof_detected),
    .out_entry_learned  (out_entry_learned),
    .out_table_full     (out_table_full),
    .out_sender_ip      (out_sender_ip),
    .out_stored_mac     (out_stored_mac),
    .out_new_mac        (out_new_mac)
  );

endmodule

// ===== sv/arpsd_checker.sv =====
// Port-level checks for the ARP reply spoof detector, bound to the top level.
// Depends on arpsd_pkg and arp_reply_spoof_detector_unit_macros.svh.
`include "arp_reply_spoof_detector_unit_macros.svh"

module arpsd_checker import arpsd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_is_reply,
  input logic              out_spoof_detected,
  input logic              out_entry_learned,
  input logic              out_table_full,
  input logic [IP_W-1:0]   out_sender_ip,
  input logic [MAC_W-1:0]  out_stored_mac,
  input logic [MAC_W-1:0]  out_new_mac
);

  // at most one verdict per result
  `ARPSD_ASSERT_IMPLY(a_one_verdict, out_valid,
    $onehot0({out_spoof_detected, out_entry_learned, out_table_full}))

  // a non-reply result carries nothing
  `ARPSD_ASSERT_IMPLY(a_non_reply_zero, out_valid && !out_is_reply,
    !out_spoof_detected && !out_entry_learned && !out_table_full &&
    out_sender_ip == '0 && out_stored_mac == '0 && out_new_mac == '0)

  // a spoof verdict needs a differing stored MAC
  `ARPSD_ASSERT_IMPLY(a_spoof_mac_differs, out_valid && out_spoof_detected,
    out_is_reply && out_stored_mac != out_new_mac)

  // learned or full results never report a stored MAC
  `ARPSD_ASSERT_IMPLY(a_no_stored_mac, out_valid && (out_entry_learned || out_table_full),
    out_is_reply && out_stored_mac == '0)

  // a stalled result holds
  `ARPSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_sender_ip) && $stable(out_new_mac))

endmodule

bind arp_reply_spoof_detector_unit arpsd_checker u_arpsd_checker (.*);
